@@ hw/rtl/kc2_pkg.sv @@
// Package for the KCipher-2 keystream engine: state types, register indexes,
// substitution and alpha-multiplication functions. No dependencies.
`default_nettype none
package kc2_pkg;

	localparam int InitClocks = 24;

	typedef enum logic [1:0] {
		REG_KEY_UPPER = 2'd0,
		REG_KEY_LOWER = 2'd1,
		REG_IV_UPPER  = 2'd2,
		REG_IV_LOWER  = 2'd3
	} reg_idx_t;

	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_DATA    = 1'b1;

	typedef struct packed {
		logic [4:0][31:0]  a;
		logic [10:0][31:0] b;
		logic [31:0]       l1;
		logic [31:0]       r1;
		logic [31:0]       l2;
		logic [31:0]       r2;
	} kc2_state_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in,
			input logic [7:0] poly);
		logic [7:0] acc;
		logic [7:0] a;
		acc = '0;
		a = a_in;
		for (int i = 0; i < 8; i++) begin
			if (b_in[i]) acc = acc ^ a;
			a = a[7] ? ({a[6:0], 1'b0} ^ poly) : {a[6:0], 1'b0};
		end
		return acc;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] s [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return s[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		logic [3:0][7:0] s;
		logic [3:0][7:0] s2;
		logic [3:0][7:0] s3;
		for (int i = 0; i < 4; i++) begin
			s[i] = sbox(w[8*i +: 8]);
			s2[i] = gf_mul(s[i], 8'h02, 8'h1b);
			s3[i] = s2[i] ^ s[i];
		end
		return {s3[0], s[0], s[0], s2[0]} ^ {s[1], s[1], s2[1], s3[1]} ^
			{s[2], s2[2], s3[2], s[2]} ^ {s2[3], s3[3], s[3], s[3]};
	endfunction

	function automatic logic [31:0] alpha_mul(input logic [1:0] k, input logic [31:0] w);
		logic [7:0] p;
		logic [31:0] c;
		logic [7:0] x;
		x = w[31:24];
		case (k)
			2'd0: begin p = 8'hC3; c = 32'hB6086D1A; end
			2'd1: begin p = 8'h2D; c = 32'hA0F5FC2E; end
			2'd2: begin p = 8'h4D; c = 32'h5BF87F93; end
			default: begin p = 8'h65; c = 32'h4559568B; end
		endcase
		return {w[23:0], 8'h00} ^ {gf_mul(x, c[31:24], p), gf_mul(x, c[23:16], p),
			gf_mul(x, c[15:8], p), gf_mul(x, c[7:0], p)};
	endfunction

	function automatic logic [31:0] nlf(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		return (a + b) ^ c ^ d;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/kc2_stream_if.sv @@
// Valid/ready channel interfaces for the keystream engine.
// Depends on nothing.
`default_nettype none
interface kc2_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] data_high;
	logic [31:0] data_low;
	modport source (output valid, kind, data_high, data_low, input ready);
	modport sink (input valid, kind, data_high, data_low, output ready);
endinterface

interface kc2_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_high;
	logic [31:0] out_low;
	modport source (output valid, out_high, out_low, input ready);
	modport sink (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/kcipher2_keystream.sv @@
// Top level of the KCipher-2 keystream engine.
// Depends on kc2_pkg, kc2_stream_if, kc2_keyload and kc2_round.
//
// Usage: write key_upper, key_lower, iv_upper, iv_lower through the cfg
// port (index 0 to 3), then send a restart beat (kind 0) on the input
// channel. The restart loads the state and runs the init clocks, one per
// cycle through the shared round logic; input ready is low while they run
// and no result is produced. Each data beat (kind 1) is XORed with
// the keystream pair from the current state and the state takes a normal
// step in the same cycle, so data beats are taken every cycle while the
// skid register is empty and no init clocks run; each result goes to the
// output register. When the receiver stalls, one further data beat is held
// in a skid register; the input side stops when both are full, and while
// init clocks run. Reset clears the state, the configuration registers and
// both valid flags. Data before any restart uses the all-zero state.
`default_nettype none
module kcipher2_keystream import kc2_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [63:0] cfg_wdata,
	kc2_in_if.sink     in_ch,
	kc2_out_if.source  out_ch
);
	logic [63:0] key_upper_q, key_lower_q, iv_upper_q, iv_lower_q;
	kc2_state_t  st_q, load, rnd_in, rnd_out;
	logic [4:0]  init_cnt_q;
	logic        busy;
	logic        out_vld_q, skid_vld_q;
	logic [31:0] out_hi_q, out_lo_q, skid_hi_q, skid_lo_q;
	logic        acc, acc_data, acc_rst, take;
	logic [31:0] zh, zl;

	kc2_keyload u_load (
		.key_upper(key_upper_q), .key_lower(key_lower_q),
		.iv_upper(iv_upper_q), .iv_lower(iv_lower_q), .load(load)
	);

	assign busy   = init_cnt_q != 5'd0;
	assign rnd_in = st_q;
	kc2_round u_round (.cur(rnd_in), .init_mode(busy), .nxt(rnd_out));

	assign in_ch.ready = !busy && !skid_vld_q;
	assign acc      = in_ch.valid && in_ch.ready;
	assign acc_data = acc && in_ch.kind == KIND_DATA;
	assign acc_rst  = acc && in_ch.kind == KIND_RESTART;
	assign take     = out_vld_q && out_ch.ready;
	assign zh = nlf(st_q.b[10], st_q.l2, st_q.l1, st_q.a[0]);
	assign zl = nlf(st_q.b[0], st_q.r2, st_q.r1, st_q.a[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			iv_upper_q  <= '0;
			iv_lower_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_UPPER: key_upper_q <= cfg_wdata;
				REG_KEY_LOWER: key_lower_q <= cfg_wdata;
				REG_IV_UPPER:  iv_upper_q  <= cfg_wdata;
				REG_IV_LOWER:  iv_lower_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			init_cnt_q <= '0;
		end else if (acc_rst) begin
			st_q <= load;
			init_cnt_q <= 5'(InitClocks);
		end else if (busy || acc_data) begin
			st_q <= rnd_out;
			if (busy) init_cnt_q <= init_cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || take) begin
				out_vld_q <= skid_vld_q || acc_data;
				skid_vld_q <= 1'b0;
			end else if (acc_data) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_hi_q <= skid_hi_q;
				out_lo_q <= skid_lo_q;
			end else begin
				out_hi_q <= in_ch.data_high ^ zh;
				out_lo_q <= in_ch.data_low ^ zl;
			end
		end
		if (acc_data) begin
			skid_hi_q <= in_ch.data_high ^ zh;
			skid_lo_q <= in_ch.data_low ^ zl;
		end
	end

	assign out_ch.valid    = out_vld_q;
	assign out_ch.out_high = out_hi_q;
	assign out_ch.out_low  = out_lo_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q) else $error("skid holds a beat while output is empty");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !acc) else $error("beat accepted during init clocks");
	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc_rst |=> init_cnt_q == 5'(InitClocks)) else $error("init count not loaded");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_hi_q))
		else $error("stalled result changed");
endmodule
`default_nettype wire

@@ hw/rtl/kc2_round.sv @@
// The KCipher-2 state update, init or normal mode, as combinational logic.
// Depends on kc2_pkg.
`default_nettype none
module kc2_round import kc2_pkg::*; (
	input  var kc2_state_t cur,
	input  wire            init_mode,
	output kc2_state_t     nxt
);
	logic [31:0] na, nb, t1, t2;

	always_comb begin
		na = alpha_mul(2'd0, cur.a[0]) ^ cur.a[3];
		if (init_mode) na = na ^ nlf(cur.b[0], cur.r2, cur.r1, cur.a[4]);
		t1 = cur.a[2][30] ? alpha_mul(2'd1, cur.b[0]) : alpha_mul(2'd2, cur.b[0]);
		t2 = cur.a[2][31] ? alpha_mul(2'd3, cur.b[8]) : cur.b[8];
		nb = t1 ^ cur.b[1] ^ cur.b[6] ^ t2;
		if (init_mode) nb = nb ^ nlf(cur.b[10], cur.l2, cur.l1, cur.a[0]);
		nxt.l1 = sub_word(cur.r2 + cur.b[4]);
		nxt.r1 = sub_word(cur.l2 + cur.b[9]);
		nxt.l2 = sub_word(cur.l1);
		nxt.r2 = sub_word(cur.r1);
		for (int m = 0; m < 4; m++) nxt.a[m] = cur.a[m+1];
		nxt.a[4] = na;
		for (int m = 0; m < 10; m++) nxt.b[m] = cur.b[m+1];
		nxt.b[10] = nb;
	end
endmodule
`default_nettype wire

@@ hw/rtl/kc2_keyload.sv @@
// Key expansion and initial state load for a restart.
// Depends on kc2_pkg.
`default_nettype none
module kc2_keyload import kc2_pkg::*; (
	input  wire [63:0] key_upper,
	input  wire [63:0] key_lower,
	input  wire [63:0] iv_upper,
	input  wire [63:0] iv_lower,
	output kc2_state_t load
);
	logic [11:0][31:0] ik;

	always_comb begin
		ik[0] = key_upper[63:32];
		ik[1] = key_upper[31:0];
		ik[2] = key_lower[63:32];
		ik[3] = key_lower[31:0];
		ik[4] = ik[0] ^ sub_word({ik[3][23:0], ik[3][31:24]}) ^ 32'h01000000;
		ik[5] = ik[1] ^ ik[4];
		ik[6] = ik[2] ^ ik[5];
		ik[7] = ik[3] ^ ik[6];
		ik[8] = ik[4] ^ sub_word({ik[7][23:0], ik[7][31:24]}) ^ 32'h02000000;
		ik[9] = ik[5] ^ ik[8];
		ik[10] = ik[6] ^ ik[9];
		ik[11] = ik[7] ^ ik[10];
		load.a = {ik[0], ik[1], ik[2], ik[3], ik[4]};
		load.b = {ik[6], ik[5], ik[7], iv_lower[31:0], iv_lower[63:32], ik[9], ik[8],
			iv_upper[31:0], iv_upper[63:32], ik[11], ik[10]};
		load.l1 = '0;
		load.r1 = '0;
		load.l2 = '0;
		load.r2 = '0;
	end
endmodule
`default_nettype wire
